// ===== rtl/mcgr_pkg.sv =====
// ----------------------------------------------------------------------------
// mcgr_pkg: shared types and constants for the multiset coefficient block
// Item layouts, the sequencer state type and the widths of the datapath.
// ----------------------------------------------------------------------------
package mcgr_pkg;

	// Largest pick count that the block computes.
	localparam int unsigned MAX_PICKS = 255;

	localparam int unsigned N_W    = 16;           // base count
	localparam int unsigned R_W    = 8;            // pick count
	localparam int unsigned COEF_W = 63;           // coefficient
	localparam int unsigned FAC_W  = N_W + 1;      // n + i - 1
	localparam int unsigned LO_W   = 32;           // low slice of the numerator
	localparam int unsigned HI_W   = COEF_W - LO_W;
	localparam int unsigned PP_W   = LO_W + FAC_W; // one partial product
	localparam int unsigned PROD_W = PP_W + LO_W;  // full product

	// Radix-16 divider: four quotient bits per cycle over a padded dividend.
	localparam int unsigned DIV_BITS  = 4;
	localparam int unsigned DIVD_W    = COEF_W + 1;
	localparam int unsigned DIV_STEPS = DIVD_W / DIV_BITS;
	localparam int unsigned DCNT_W    = $clog2(DIV_STEPS);

	localparam logic [COEF_W-1:0] COEF_LIMIT = {COEF_W{1'b1}};

	typedef struct packed {
		logic [N_W-1:0] base_count;
		logic [R_W-1:0] pick_count;
	} mcgr_item_t;

	typedef struct packed {
		logic [COEF_W-1:0] coefficient;
		logic              overflow;
	} mcgr_coef_t;

	// Request to the divider and its reply.
	typedef struct packed {
		logic              start;
		logic [COEF_W-1:0] dividend;
		logic [R_W-1:0]    divisor;
	} mcgr_div_req_t;

	typedef struct packed {
		logic              done;
		logic [COEF_W-1:0] quotient;
	} mcgr_div_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_CHECK,
		ST_DIV,
		ST_FINISH
	} mcgr_state_t;

endpackage

// ===== rtl/multiset_coefficient_gcd_reduced.sv =====
// ----------------------------------------------------------------------------
// multiset_coefficient_gcd_reduced: n multichoose r
// Sequencer round by round over one shared multiplier and one divider.
// ----------------------------------------------------------------------------
// One item (n, r) gives one result C(n+r-1, r). The block takes one item at a
// time and holds item_stall high until its result is in the output register;
// a waiting result does not block the next item. Each of the r rounds
// multiplies the running coefficient by n+i-1 on a 32x17 multiplier in two
// passes, checks the full product against 2^63-1 and divides it by i on a
// radix-16 divider, whose sixteen steps take up most of each round. Pick
// count zero, base count zero and an overflow finish early. On overflow the
// coefficient reads 2^63-1 with the overflow flag set.
module multiset_coefficient_gcd_reduced
	import mcgr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  mcgr_item_t item,
	output logic       coef_valid,
	input  logic       coef_stall,
	output mcgr_coef_t coef
);

	mcgr_state_t state_q, state_d;

	logic [N_W-1:0]    n_q;
	logic [R_W-1:0]    r_q;
	logic [R_W-1:0]    i_q;
	logic [COEF_W-1:0] num_q;
	logic [PP_W-1:0]   plo_q;
	logic [PP_W-1:0]   phi_q;
	mcgr_coef_t        res_q;
	logic              coef_valid_q;
	mcgr_coef_t        coef_q;

	logic              accept;
	logic              slot_free;
	logic              last_round;
	logic [FAC_W-1:0]  fac;
	logic [LO_W-1:0]   mul_a;
	logic [PP_W-1:0]   mul_p;
	logic [PROD_W-1:0] prod;
	logic              prod_ovf;
	logic              is_special;

	mcgr_div_req_t     div_req;
	mcgr_div_rsp_t     div_rsp;

	assign accept     = item_valid && !item_stall;
	assign slot_free  = !coef_valid_q || !coef_stall;
	assign last_round = (i_q == r_q);
	assign is_special = (item.pick_count == '0) || (item.base_count == '0)
		|| ({{(32-R_W){1'b0}}, item.pick_count} > 32'(MAX_PICKS));

	// Shared multiplier: low slice first, then high slice.
	assign fac   = {1'b0, n_q} + {{(FAC_W-R_W){1'b0}}, i_q} - FAC_W'(1);
	assign mul_a = (state_q == ST_MUL_LO) ? num_q[LO_W-1:0]
		: {{(LO_W-HI_W){1'b0}}, num_q[COEF_W-1:LO_W]};
	assign mul_p = {{(PP_W-LO_W){1'b0}}, mul_a} * {{(PP_W-FAC_W){1'b0}}, fac};

	// Join the partial products and test against the coefficient limit.
	assign prod     = {phi_q, {LO_W{1'b0}}} + {{LO_W{1'b0}}, plo_q};
	assign prod_ovf = (prod[PROD_W-1:COEF_W] != '0);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = is_special ? ST_FINISH : ST_MUL_LO;
				end
			end
			ST_MUL_LO: state_d = ST_MUL_HI;
			ST_MUL_HI: state_d = ST_CHECK;
			ST_CHECK:  state_d = prod_ovf ? ST_FINISH : ST_DIV;
			ST_DIV: begin
				if (div_rsp.done) begin
					state_d = last_round ? ST_FINISH : ST_MUL_LO;
				end
			end
			ST_FINISH: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		item_stall       = (state_q != ST_IDLE);
		div_req.start    = (state_q == ST_CHECK) && !prod_ovf;
		div_req.dividend = prod[COEF_W-1:0];
		div_req.divisor  = i_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath: load the item, run the rounds, settle the result.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				n_q   <= item.base_count;
				r_q   <= item.pick_count;
				i_q   <= R_W'(1);
				num_q <= COEF_W'(1);
				if (item.pick_count == '0) begin
					res_q <= '{coefficient: COEF_W'(1), overflow: 1'b0};
				end else if (item.base_count == '0) begin
					res_q <= '{coefficient: '0, overflow: 1'b0};
				end else begin
					res_q <= '{coefficient: COEF_LIMIT, overflow: 1'b1};
				end
			end
			ST_MUL_LO: plo_q <= mul_p;
			ST_MUL_HI: phi_q <= mul_p;
			ST_CHECK: begin
				if (prod_ovf) begin
					res_q <= '{coefficient: COEF_LIMIT, overflow: 1'b1};
				end
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					num_q <= div_rsp.quotient;
					i_q   <= i_q + 1'b1;
					res_q <= '{coefficient: div_rsp.quotient, overflow: 1'b0};
				end
			end
			default: begin
			end
		endcase
	end

	// Output register: hold the result until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_valid_q <= 1'b0;
		end else if (state_q == ST_FINISH && slot_free) begin
			coef_valid_q <= 1'b1;
		end else if (!coef_stall) begin
			coef_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && slot_free) begin
			coef_q <= res_q;
		end
	end

	assign coef_valid = coef_valid_q;
	assign coef       = coef_q;

	mcgr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

endmodule

// ===== rtl/mcgr_div.sv =====
// ----------------------------------------------------------------------------
// mcgr_div: iterative divider of the numerator by the round index
// Restoring division, four quotient bits per cycle, narrow divisor.
// ----------------------------------------------------------------------------
module mcgr_div
	import mcgr_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  mcgr_div_req_t req,
	output mcgr_div_rsp_t rsp
);

	logic              busy_q;
	logic              done_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [DIVD_W-1:0] work_q;
	logic [R_W-1:0]    rem_q;
	logic [R_W-1:0]    dsr_q;

	logic [DIVD_W-1:0] work_d;
	logic [R_W:0]      rem_d;

	// Take four dividend bits per cycle, shifting quotient bits in behind them.
	always_comb begin
		work_d = work_q;
		rem_d  = {1'b0, rem_q};
		for (int k = 0; k < DIV_BITS; k++) begin
			rem_d  = {rem_d[R_W-1:0], work_d[DIVD_W-1]};
			work_d = {work_d[DIVD_W-2:0], 1'b0};
			if (rem_d >= {1'b0, dsr_q}) begin
				rem_d     = rem_d - {1'b0, dsr_q};
				work_d[0] = 1'b1;
			end
		end
	end

	// Sequence the steps and flag the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == DCNT_W'(DIV_STEPS - 1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DCNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Hold operands and partial results.
	always_ff @(posedge clk) begin
		if (req.start) begin
			work_q <= {1'b0, req.dividend};
			rem_q  <= '0;
			dsr_q  <= req.divisor;
		end else if (busy_q) begin
			work_q <= work_d;
			rem_q  <= rem_d[R_W-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = work_q[COEF_W-1:0];

endmodule

// ===== rtl/mcgr_checker.sv =====
// ----------------------------------------------------------------------------
// mcgr_checker: port-level checks for the multiset coefficient block
// Watches the handshakes and the result encoding seen at the top level.
// ----------------------------------------------------------------------------
module mcgr_checker
	import mcgr_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       item_valid,
	input logic       item_stall,
	input mcgr_item_t item,
	input logic       coef_valid,
	input logic       coef_stall,
	input mcgr_coef_t coef
);

	// A stalled result stays offered.
	a_coef_hold: assert property (@(posedge clk) disable iff (!arst_n)
		coef_valid && coef_stall |=> coef_valid && $stable(coef))
		else $error("result dropped or changed under stall");

	// An overflow always reads as the saturated coefficient.
	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		coef_valid && coef.overflow |-> coef.coefficient == COEF_LIMIT)
		else $error("overflow without saturated coefficient");

	// Once an item is taken the block holds off the next one.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("second item taken while busy");

	// No picks gives one, by way of the finish state, when the output is free.
	a_no_picks: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && item.pick_count == '0 && !coef_valid
		|=> ##1 coef_valid && coef.coefficient == COEF_W'(1) && !coef.overflow)
		else $error("wrong result for zero picks");

endmodule

bind multiset_coefficient_gcd_reduced mcgr_checker u_mcgr_checker (.*);

// ===== tb/sv/multiset_coefficient_gcd_reduced_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multiset_coefficient_gcd_reduced_tb: self-checking bench for n multichoose r
// Drives (n, r) items through the valid/stall handshake with random gaps and
// back-pressure. Each accepted item is predicted by a behavioural model of the
// rounds: the fraction is reduced by its gcd and overflow is detected. Each
// result is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module multiset_coefficient_gcd_reduced_tb;
	import mcgr_pkg::*;

	localparam int unsigned IDLE_LIMIT  = 60000; // cycles with no handshake at all
	localparam int unsigned DRAIN_WAIT  = 64;    // quiet cycles after the last result
	localparam int unsigned RAND_ITEMS  = 120;
	localparam logic [63:0] COEF_MAX64  = {1'b0, COEF_LIMIT};

	typedef struct {
		mcgr_item_t src;
		mcgr_coef_t coef;
	} coef_pending_t;

	// Scoreboard: predicts each accepted item and matches results in order
	class multichoose_board;
		coef_pending_t pending[$];
		int unsigned   mismatches = 0;

		// Work out n multichoose r as the block's rounds do
		function mcgr_coef_t multichoose(input logic [N_W-1:0] n, input logic [R_W-1:0] r);
			logic [63:0] num, den, fac, a, b, t;
			int unsigned i;
			mcgr_coef_t res;
			res.coefficient = '0;
			res.overflow    = 1'b0;
			if (r == 0) begin
				res.coefficient = COEF_W'(1);
				return res;
			end
			if (n == 0)
				return res;
			if (r > MAX_PICKS) begin
				res.coefficient = COEF_LIMIT;
				res.overflow    = 1'b1;
				return res;
			end
			num = 64'd1;
			den = 64'd1;
			for (i = 1; i <= r; i++) begin
				fac = 64'(n) + 64'(i) - 64'd1;
				if (num > COEF_MAX64 / fac || den > COEF_MAX64 / 64'(i)) begin
					res.coefficient = COEF_LIMIT;
					res.overflow    = 1'b1;
					return res;
				end
				num = num * fac;
				den = den * 64'(i);
				// reduce by the gcd, Euclid's remainder loop
				a = num;
				b = den;
				if (a < b) begin
					t = a;
					a = b;
					b = t;
				end
				while (b != 0) begin
					t = a % b;
					a = b;
					b = t;
				end
				if (a != 0) begin
					num = num / a;
					den = den / a;
				end
			end
			if (den == 0)
				den = 64'd1;
			res.coefficient = COEF_W'(num / den);
			return res;
		endfunction

		function void note_item(input mcgr_item_t it);
			coef_pending_t p;
			p.src   = it;
			p.coef  = multichoose(it.base_count, it.pick_count);
			pending = {pending, p};
		endfunction

		function void check_coef(input mcgr_coef_t got);
			coef_pending_t p;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual coefficient %0d overflow %0b",
					$time, got.coefficient, got.overflow);
				mismatches++;
				return;
			end
			p = pending.pop_front();
			if (got.coefficient !== p.coef.coefficient) begin
				$display("%0t: n=%0d r=%0d coefficient expected %0d, actual %0d", $time,
					p.src.base_count, p.src.pick_count, p.coef.coefficient, got.coefficient);
				mismatches++;
			end
			if (got.overflow !== p.coef.overflow) begin
				$display("%0t: n=%0d r=%0d overflow expected %0b, actual %0b", $time,
					p.src.base_count, p.src.pick_count, p.coef.overflow, got.overflow);
				mismatches++;
			end
		endfunction
	endclass

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       item_valid = 1'b0;
	logic       item_stall;
	mcgr_item_t item       = '0;
	logic       coef_valid;
	logic       coef_stall = 1'b0;
	mcgr_coef_t coef;

	bit              no_idle = 1'b0;
	int unsigned     idle_cycles = 0;
	multichoose_board board = new();

	multiset_coefficient_gcd_reduced uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.coef_valid (coef_valid),
		.coef_stall (coef_stall),
		.coef       (coef)
	);

	always #6 clk = ~clk;

	// Draw a wait for one handshake, none during a busy stretch
	function automatic int unsigned draw_gap();
		return no_idle ? 0 : $urandom_range(0, 18);
	endfunction

	// Offer one item after a random gap and hold it until accepted
	task automatic offer_item(input logic [N_W-1:0] n, input logic [R_W-1:0] r);
		int unsigned gap;
		gap = draw_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= '{base_count: n, pick_count: r};
		do @(posedge clk); while (!(item_valid && !item_stall));
	endtask

	// Note accepted items and check accepted results
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall)
				board.note_item(item);
			if (coef_valid && !coef_stall)
				board.check_coef(coef);
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (coef_valid && !coef_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Result side: stall for a random count before each result
	initial begin : coef_sink
		int unsigned hold;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			hold = draw_gap();
			if (hold > 0) begin
				coef_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			coef_stall <= 1'b0;
			do @(posedge clk); while (!(coef_valid && !coef_stall));
		end
	end

	// Stimulus
	initial begin : stimulus
		int unsigned k, sel_n, sel_r;
		logic [N_W-1:0] n;
		logic [R_W-1:0] r;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: no picks, no kinds, extremes, long runs and overflow
		offer_item(16'd0, 8'd0);
		offer_item(16'd65535, 8'd0);
		offer_item(16'd0, 8'd1);
		offer_item(16'd0, 8'd255);
		offer_item(16'd1, 8'd1);
		offer_item(16'd1, 8'd255);
		offer_item(16'd2, 8'd255);
		offer_item(16'd65535, 8'd1);
		offer_item(16'd65535, 8'd3);
		offer_item(16'd65535, 8'd4);
		offer_item(16'd65535, 8'd5);
		offer_item(16'd65535, 8'd255);
		offer_item(16'd5, 8'd3);
		offer_item(16'd10, 8'd10);
		offer_item(16'd3, 8'd40);
		offer_item(16'd31, 8'd31);
		offer_item(16'd33, 8'd33);
		offer_item(16'd4, 8'd128);
		offer_item(16'd32768, 8'd2);
		offer_item(16'd255, 8'd254);

		// random: mostly modest sizes, a few full range
		for (k = 0; k < RAND_ITEMS; k++) begin
			if (k % 20 == 0)
				no_idle = ($urandom_range(0, 2) == 0);
			// hold off until the block has drained
			if (k == RAND_ITEMS / 2) begin
				item_valid <= 1'b0;
				do @(posedge clk); while (board.pending.size() != 0);
			end
			sel_n = $urandom_range(0, 9);
			sel_r = $urandom_range(0, 9);
			if (sel_n == 0)
				n = '0;
			else if (sel_n <= 4)
				n = N_W'($urandom_range(1, 12));
			else if (sel_n <= 6)
				n = N_W'($urandom_range(13, 300));
			else
				n = N_W'($urandom_range(0, 65535));
			if (sel_r == 0)
				r = '0;
			else if (sel_r <= 6)
				r = R_W'($urandom_range(1, 24));
			else if (sel_r <= 8)
				r = R_W'($urandom_range(25, 80));
			else
				r = R_W'($urandom_range(0, 255));
			offer_item(n, r);
		end
		item_valid <= 1'b0;
		no_idle = 1'b0;

		// drain, then allow for stray results
		do @(posedge clk); while (board.pending.size() != 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/mcgr_pkg.sv
rtl/mcgr_div.sv
rtl/multiset_coefficient_gcd_reduced.sv
rtl/mcgr_checker.sv
tb/sv/multiset_coefficient_gcd_reduced_tb.sv
